// ===== rtl/core/ple_pkg.sv =====
// Shared constants, types and helper functions for the positional list engine.
package ple_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int POS_W      = 5;
  localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef logic [DATA_WIDTH-1:0] data_t;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    op_t                operation;
    logic [POS_W-1:0]   position;
    logic signed [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] read_data;
    status_t            status;
    logic [4:0]         length;
  } result_t;

  typedef struct packed {
    logic load;
    logic take_left;
    logic take_right;
  } cell_ctl_t;

  function automatic data_t to_data(input logic [31:0] v);
    logic [63:0] w;
    begin
      w = {32'b0, v};
      return w[DATA_WIDTH-1:0];
    end
  endfunction

  function automatic logic [31:0] to_word(input data_t d);
    logic signed [63:0] w;
    begin
      w = 64'(signed'(d));
      return w[31:0];
    end
  endfunction

endpackage

// ===== rtl/core/ple_cell.sv =====
// One list cell: holds one entry and shifts toward either neighbor or loads a new value.
module ple_cell
  import ple_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  data_t     left_data,
  input  data_t     right_data,
  input  data_t     load_data,
  output data_t     data
);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      data <= load_data;
    end else if (ctl.take_left) begin
      data <= left_data;
    end else if (ctl.take_right) begin
      data <= right_data;
    end
  end

endmodule

// ===== rtl/core/positional_list_engine.sv =====
// Top level of the positional list engine: command decode, cell chain and result register.
// A command accepted at one edge gives its result
// on done in the very next cycle, and busy is low at all times outside reset, so a
// command may follow in every cycle. All cells shift at once, so the cost of an
// insert or delete does not depend on the position. The result is shown for one
// cycle only and the receiver must take it then.
module positional_list_engine
  import ple_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  cmd_t    cmd,
  output logic    busy,
  output logic    done,
  output result_t result
);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             accept;
  logic [CMP_W-1:0] pos_x;
  logic [CMP_W-1:0] cnt_x;
  logic             ins_ok;
  logic             del_ok;
  status_t          status_next;
  logic [31:0]      rdata_next;
  data_t            cell_data [CAPACITY];
  data_t            ins_data;

  assign busy     = rst;
  assign accept   = start && !busy;
  assign pos_x    = CMP_W'(cmd.position);
  assign cnt_x    = CMP_W'(count);
  assign ins_data = to_data(cmd.value);

  always_comb begin
    status_next = ST_OK;
    rdata_next  = '0;
    ins_ok      = 1'b0;
    del_ok      = 1'b0;
    unique case (cmd.operation)
      OP_INSERT: begin
        if (pos_x > cnt_x) begin
          status_next = ST_RANGE;
        end else if (count == CNT_W'(CAPACITY)) begin
          status_next = ST_FULL;
        end else begin
          ins_ok = 1'b1;
        end
      end
      OP_DELETE: begin
        if (count == '0) begin
          status_next = ST_EMPTY;
        end else if (pos_x >= cnt_x) begin
          status_next = ST_RANGE;
        end else begin
          del_ok = 1'b1;
        end
      end
      OP_READ: begin
        if (pos_x >= cnt_x) begin
          status_next = ST_RANGE;
        end else begin
          rdata_next = to_word(cell_data[pos_x[IDX_W-1:0]]);
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  always_comb begin
    count_next = count;
    if (accept && ins_ok) begin
      count_next = count + CNT_W'(1);
    end else if (accept && del_ok) begin
      count_next = count - CNT_W'(1);
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CMP_W-1:0] IDX = CMP_W'(i);
    cell_ctl_t ctl;
    data_t     left_data;
    data_t     right_data;

    assign ctl.load       = accept && ins_ok && (pos_x == IDX);
    assign ctl.take_left  = accept && ins_ok && (pos_x < IDX);
    assign ctl.take_right = accept && del_ok && (pos_x <= IDX);

    if (i == 0) begin : g_first
      assign left_data = '0;
    end else begin : g_inner_l
      assign left_data = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_data = '0;
    end else begin : g_inner_r
      assign right_data = cell_data[i+1];
    end

    ple_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .left_data  (left_data),
      .right_data (right_data),
      .load_data  (ins_data),
      .data       (cell_data[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.read_data <= rdata_next;
      result.status    <= status_next;
      result.length    <= 5'(count_next);
    end
  end

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_done_follows_accept : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept))
    else $error("result strobe without an accepted transaction");

  a_error_keeps_count : assert property (@(posedge clk) disable iff (rst)
    (accept && status_next != ST_OK) |=> (count == $past(count)))
    else $error("failed transaction changed the entry count");

  a_length_matches : assert property (@(posedge clk) disable iff (rst)
    done |-> (result.length == 5'(count)))
    else $error("reported length differs from entry count");

endmodule

// ===== verif/tb_positional_list_engine.sv =====
// Self-checking testbench for the positional list engine: directed and random command traffic.
module tb_positional_list_engine;
  import ple_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 4;
  localparam int MAX_REPORTS = 10;
  localparam int CMD_W       = $bits(cmd_t);

  logic    clk;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  cmd_t    cmd = '0;
  logic    busy;
  logic    done;
  result_t result;

  data_t   shadow_cells[CAPACITY];
  int      shadow_len = 0;
  int      peak_len = 0;
  int      status_seen[4] = '{0, 0, 0, 0};
  int      cmd_count = 0;
  int      result_count = 0;
  int      err_count = 0;
  int      stall_cycles = 0;
  result_t pending_results[$];

  positional_list_engine uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic result_t apply_list_cmd(input cmd_t c);
    result_t r;
    int      pos;
    begin
      r = '0;
      r.status = ST_OK;
      pos = int'(c.position);
      case (c.operation)
        OP_INSERT: begin
          if (pos > shadow_len) begin
            r.status = ST_RANGE;
          end else if (shadow_len >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            for (int i = shadow_len; i > pos; i--) shadow_cells[i] = shadow_cells[i-1];
            shadow_cells[pos] = data_t'($unsigned(c.value));
            shadow_len++;
          end
        end
        OP_DELETE: begin
          if (shadow_len == 0) begin
            r.status = ST_EMPTY;
          end else if (pos >= shadow_len) begin
            r.status = ST_RANGE;
          end else begin
            for (int i = pos; i + 1 < shadow_len; i++) shadow_cells[i] = shadow_cells[i+1];
            shadow_len--;
          end
        end
        OP_READ: begin
          if (pos >= shadow_len || pos >= CAPACITY) begin
            r.status = ST_RANGE;
          end else begin
            r.read_data = 32'(signed'(shadow_cells[pos]));
          end
        end
        default: begin
        end
      endcase
      r.length = 5'(shadow_len);
      if (shadow_len > peak_len) peak_len = shadow_len;
      status_seen[r.status]++;
      return r;
    end
  endfunction

  function automatic cmd_t make_cmd(input op_t op, input int pos, input logic [31:0] val);
    cmd_t c;
    begin
      c.operation = op;
      c.position  = 5'(pos);
      c.value     = val;
      return c;
    end
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_cmd(input cmd_t c);
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
    pending_results.push_back(apply_list_cmd(c));
    cmd_count++;
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic test_directed();
    send_cmd(make_cmd(OP_READ, 0, 32'h1234_5678));
    send_cmd(make_cmd(OP_DELETE, 31, 32'h0));
    send_cmd(make_cmd(OP_INSERT, 1, 32'hdead_beef));
    send_cmd(make_cmd(OP_NONE, 21, 32'hffff_ffff));
    send_cmd(make_cmd(OP_INSERT, 0, 32'h8000_0000));
    send_cmd(make_cmd(OP_INSERT, 0, 32'h7fff_ffff));
    send_cmd(make_cmd(OP_INSERT, 2, 32'hffff_ffff));
    send_cmd(make_cmd(OP_READ, 0, 32'h0));
    send_cmd(make_cmd(OP_READ, 2, 32'h0));
    send_cmd(make_cmd(OP_READ, 3, 32'h0));
    send_cmd(make_cmd(OP_DELETE, 3, 32'h0));
    while (shadow_len < CAPACITY) begin
      send_cmd(make_cmd(OP_INSERT, $urandom_range(shadow_len), pick_value()));
    end
    send_cmd(make_cmd(OP_INSERT, CAPACITY, 32'h5555_aaaa));
    send_cmd(make_cmd(OP_INSERT, 31, 32'haaaa_5555));
    send_cmd(make_cmd(OP_READ, CAPACITY - 1, 32'h0));
    send_cmd(make_cmd(OP_READ, CAPACITY, 32'h0));
    send_cmd(make_cmd(OP_DELETE, CAPACITY - 1, 32'h0));
    send_cmd(make_cmd(OP_DELETE, 0, 32'h0));
  endtask

  task automatic test_random(input int n, input int idle_pct);
    bit   filling;
    int   r;
    op_t  op;
    int   pos;
    begin
      filling = (shadow_len < CAPACITY / 2);
      for (int k = 0; k < n; k++) begin
        if (k == n / 2) wait_for_results();
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
          start <= 1'b0;
          cmd   <= cmd_t'(CMD_W'({$urandom, $urandom}));
          repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        if (shadow_len == CAPACITY) filling = 1'b0;
        else if (shadow_len == 0) filling = 1'b1;
        r = $urandom_range(99);
        if (r < 3) op = OP_NONE;
        else if (r < (filling ? 58 : 23)) op = OP_INSERT;
        else if (r < 78) op = OP_DELETE;
        else op = OP_READ;
        if ($urandom_range(7) == 0) pos = $urandom_range(31);
        else if (op == OP_INSERT) pos = $urandom_range(shadow_len);
        else pos = (shadow_len == 0) ? 0 : $urandom_range(shadow_len - 1);
        send_cmd(make_cmd(op, pos, pick_value()));
      end
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      result_count++;
      if (pending_results.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("Unexpected result: read_data=%h status=%0d length=%0d",
                   result.read_data, result.status, result.length);
      end else begin
        want = pending_results.pop_front();
        if (result.read_data !== want.read_data || result.status !== want.status ||
            result.length !== want.length) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("Mismatch: expected %h/%0d/%0d, got %h/%0d/%0d (data/status/length)",
                     want.read_data, want.status, want.length,
                     result.read_data, result.status, result.length);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles.", STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(267, 7);
    test_random(267, 73);
    test_random(266, 0);
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      err_count++;
      $display("%0d expected results never arrived.", pending_results.size());
    end
    $display("Covered %0d commands and %0d results, peak length %0d of %0d.",
             cmd_count, result_count, peak_len, CAPACITY);
    $display("Status mix: %0d ok, %0d out of range, %0d empty, %0d full; %0d errors.",
             status_seen[ST_OK], status_seen[ST_RANGE], status_seen[ST_EMPTY],
             status_seen[ST_FULL], err_count);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
